FILE: sv/pbre_pkg.sv
// shared constants and control types for the packbits row encoder
`timescale 1ns / 1ps

package pbre_pkg;

    localparam int MAX_PACKET = 128;
    localparam int OUT_LANES  = 8;

    localparam int BYTE_W    = 8;
    localparam int CODE_W    = 64;
    localparam int LANE_W    = 4;
    localparam int COUNT_W   = $clog2(MAX_PACKET + 2);
    localparam int ADDR_W    = $clog2(MAX_PACKET);
    localparam int COL_W     = 15;
    localparam int ROW_W     = 16;
    localparam int LEN_W     = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH       = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_CHANNEL = 1'b1;

    typedef struct packed {
        logic accept;
        logic emit;
        logic sel_b;
    } pbre_cmd_t;

    typedef struct packed {
        logic new_has_a;
        logic has_b;
        logic byte_last;
        logic out_free;
    } pbre_status_t;

endpackage

FILE: sv/pbre_ctrl.sv
// controller state machine sequencing byte intake and packet emission
`timescale 1ns / 1ps

module pbre_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  pbre_pkg::pbre_status_t status,
    output pbre_pkg::pbre_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EMIT_A,
        S_EMIT_B
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_stall_reg;
    logic   in_stall_next;

    always_comb
    begin
        cmd.accept = in_valid && (state_reg == S_IDLE);
        cmd.emit   = (state_reg != S_IDLE) && status.out_free;
        cmd.sel_b  = (state_reg == S_EMIT_B);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.accept && status.new_has_a)
                begin
                    state_next = S_EMIT_A;
                end
            end
            S_EMIT_A:
            begin
                if (cmd.emit && status.byte_last)
                begin
                    state_next = status.has_b ? S_EMIT_B : S_IDLE;
                end
            end
            S_EMIT_B:
            begin
                if (cmd.emit && status.byte_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        in_stall_next = (state_next != S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_stall_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_stall_reg <= in_stall_next;
        end
    end

    assign in_stall = in_stall_reg;

endmodule

FILE: sv/pbre_datapath.sv
// datapath: packet decisions, literal memory, word packing and output register
`timescale 1ns / 1ps

module pbre_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pbre_pkg::pbre_cmd_t                  cmd,
    output pbre_pkg::pbre_status_t               status,
    input  logic                                cfg_write_en,
    input  logic [pbre_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pbre_pkg::CFG_W-1:0]           cfg_data,
    input  logic [pbre_pkg::BYTE_W-1:0]          data_byte,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [pbre_pkg::CODE_W-1:0]          code_bytes,
    output logic [pbre_pkg::LANE_W-1:0]          byte_count,
    output logic                                packet_end,
    output logic                                row_end,
    output logic [pbre_pkg::LEN_W-1:0]           row_code_length,
    output logic                                channel_end,
    output logic                                last
);

    localparam int COUNT_W = pbre_pkg::COUNT_W;
    localparam int ADDR_W  = pbre_pkg::ADDR_W;
    localparam int BYTE_W  = pbre_pkg::BYTE_W;
    localparam int LANE_W  = pbre_pkg::LANE_W;
    localparam int CODE_W  = pbre_pkg::CODE_W;
    localparam int COL_W   = pbre_pkg::COL_W;
    localparam int ROW_W   = pbre_pkg::ROW_W;
    localparam int LEN_W   = pbre_pkg::LEN_W;

    localparam logic [COUNT_W-1:0] PKT_MAX = COUNT_W'(pbre_pkg::MAX_PACKET);
    localparam logic [COUNT_W-1:0] LIT_CAP = COUNT_W'(pbre_pkg::MAX_PACKET - 1);
    localparam logic [COUNT_W-1:0] MIN_RUN = COUNT_W'(3);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_RUN,
        MODE_LIT
    } mode_t;

    typedef struct packed {
        logic               is_lit;
        logic [BYTE_W-1:0]  header;
        logic [BYTE_W-1:0]  value;
        logic [COUNT_W-1:0] len;
    } packet_t;

    function automatic packet_t run_packet(input logic [COUNT_W-1:0] n,
                                           input logic [BYTE_W-1:0] v);
        packet_t p;
        p.is_lit = 1'b0;
        p.header = BYTE_W'(9'd257 - 9'(n));
        p.value  = v;
        p.len    = COUNT_W'(2);
        return p;
    endfunction

    function automatic packet_t single_packet(input logic [BYTE_W-1:0] v);
        packet_t p;
        p.is_lit = 1'b0;
        p.header = '0;
        p.value  = v;
        p.len    = COUNT_W'(2);
        return p;
    endfunction

    function automatic packet_t pair_packet(input logic [BYTE_W-1:0] v);
        packet_t p;
        p.is_lit = 1'b0;
        p.header = BYTE_W'(1);
        p.value  = v;
        p.len    = COUNT_W'(3);
        return p;
    endfunction

    function automatic packet_t lit_packet(input logic [COUNT_W-1:0] n);
        packet_t p;
        p.is_lit = 1'b1;
        p.header = BYTE_W'(n - COUNT_W'(1));
        p.value  = '0;
        p.len    = COUNT_W'(n + COUNT_W'(1));
        return p;
    endfunction

    // configuration
    logic [COL_W-1:0]   row_width_reg;
    logic [ROW_W-1:0]   rows_reg;

    // coder state
    mode_t              mode_reg;
    mode_t              mode_next;
    logic [BYTE_W-1:0]  run_value_reg;
    logic [BYTE_W-1:0]  run_value_next;
    logic [COUNT_W-1:0] held_count_reg;
    logic [COUNT_W-1:0] held_count_next;
    logic [BYTE_W-1:0]  pending_byte_reg;
    logic [BYTE_W-1:0]  pending_byte_next;
    logic [BYTE_W-1:0]  lead_byte_reg;
    logic [BYTE_W-1:0]  lead_byte_next;
    logic [COL_W-1:0]   column_reg;
    logic [ROW_W-1:0]   row_index_reg;
    logic [LEN_W-1:0]   row_total_reg;

    // decided packets of the current byte
    packet_t            pkt_a_reg;
    packet_t            pkt_b_reg;
    logic               b_valid_reg;
    logic [LEN_W-1:0]   row_len_reg;
    logic               row_end_flag_reg;
    logic               chan_flag_reg;

    // emission
    logic [COUNT_W-1:0] ptr_reg;
    logic [COUNT_W-1:0] ptr_next;
    logic [LANE_W-1:0]  fill_reg;
    logic [CODE_W-1:0]  word_reg;
    logic               out_valid_reg;

    // literal memory
    logic [BYTE_W-1:0]  lit_mem [pbre_pkg::MAX_PACKET];
    logic [BYTE_W-1:0]  mem_rdata_reg;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [BYTE_W-1:0]  mem_wdata;
    logic [ADDR_W-1:0]  mem_raddr;

    // decision wires
    logic               is_last;
    logic               chan_done;
    logic [COUNT_W-1:0] run_inc;
    logic [COUNT_W-1:0] lit_count;
    logic [COUNT_W-1:0] lit_inc;
    logic [COUNT_W-1:0] run_lit_count;
    packet_t            pkt_a;
    packet_t            pkt_b;
    logic               a_valid;
    logic               b_valid;
    logic [LEN_W-1:0]   row_len;

    // emission wires
    packet_t            cur_pkt;
    logic [BYTE_W-1:0]  cur_byte;
    logic               byte_last;
    logic               step_last;
    logic               flush;
    logic [CODE_W-1:0]  word_ins;
    logic [LANE_W-1:0]  fill_inc;
    logic               out_free;

    always_comb
    begin
        is_last   = (COL_W'(column_reg + COL_W'(1)) == row_width_reg);
        chan_done = (ROW_W'(row_index_reg + ROW_W'(1)) == rows_reg);
        run_inc   = COUNT_W'(held_count_reg + COUNT_W'(1));
        run_lit_count = (held_count_reg == '0) ? COUNT_W'(1) : held_count_reg;
        if (held_count_reg == '0)
        begin
            lit_count = COUNT_W'(1);
        end
        else if (held_count_reg > LIT_CAP)
        begin
            lit_count = LIT_CAP;
        end
        else
        begin
            lit_count = held_count_reg;
        end
        lit_inc = COUNT_W'(lit_count + COUNT_W'(1));

        mode_next         = mode_reg;
        run_value_next    = run_value_reg;
        held_count_next   = held_count_reg;
        pending_byte_next = pending_byte_reg;
        lead_byte_next    = lead_byte_reg;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        a_valid   = 1'b0;
        b_valid   = 1'b0;
        pkt_a     = '0;
        pkt_b     = '0;

        case (mode_reg)
            MODE_RUN:
            begin
                if (data_byte == run_value_reg)
                begin
                    if (run_inc >= PKT_MAX)
                    begin
                        a_valid   = 1'b1;
                        pkt_a     = run_packet(PKT_MAX, run_value_reg);
                        mode_next = MODE_IDLE;
                    end
                    else if (is_last)
                    begin
                        a_valid = 1'b1;
                        pkt_a   = (run_inc >= MIN_RUN) ? run_packet(run_inc, run_value_reg)
                                                       : pair_packet(run_value_reg);
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        held_count_next = run_inc;
                    end
                end
                else if (held_count_reg >= MIN_RUN)
                begin
                    a_valid = 1'b1;
                    pkt_a   = run_packet(held_count_reg, run_value_reg);
                    if (is_last)
                    begin
                        b_valid   = 1'b1;
                        pkt_b     = single_packet(data_byte);
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        mode_next       = MODE_RUN;
                        run_value_next  = data_byte;
                        held_count_next = COUNT_W'(1);
                    end
                end
                else
                begin
                    // first two literal bytes: entry zero in a register, entry one in memory
                    lead_byte_next = run_value_reg;
                    mem_we    = 1'b1;
                    mem_waddr = ADDR_W'(1);
                    mem_wdata = run_value_reg;
                    if (is_last)
                    begin
                        a_valid   = 1'b1;
                        pkt_a     = lit_packet(run_lit_count);
                        b_valid   = 1'b1;
                        pkt_b     = single_packet(data_byte);
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        mode_next         = MODE_LIT;
                        held_count_next   = run_lit_count;
                        pending_byte_next = data_byte;
                    end
                end
            end
            MODE_LIT:
            begin
                if (pending_byte_reg == data_byte)
                begin
                    a_valid = 1'b1;
                    pkt_a   = lit_packet(lit_count);
                    if (is_last)
                    begin
                        b_valid   = 1'b1;
                        pkt_b     = pair_packet(pending_byte_reg);
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        mode_next       = MODE_RUN;
                        run_value_next  = pending_byte_reg;
                        held_count_next = COUNT_W'(2);
                    end
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_waddr = lit_count[ADDR_W-1:0];
                    mem_wdata = pending_byte_reg;
                    if (lit_inc >= PKT_MAX || is_last)
                    begin
                        a_valid = 1'b1;
                        pkt_a   = lit_packet(lit_inc);
                        if (is_last)
                        begin
                            b_valid   = 1'b1;
                            pkt_b     = single_packet(data_byte);
                            mode_next = MODE_IDLE;
                        end
                        else
                        begin
                            mode_next       = MODE_RUN;
                            run_value_next  = data_byte;
                            held_count_next = COUNT_W'(1);
                        end
                    end
                    else
                    begin
                        held_count_next   = lit_inc;
                        pending_byte_next = data_byte;
                    end
                end
            end
            default:
            begin
                if (is_last)
                begin
                    a_valid   = 1'b1;
                    pkt_a     = single_packet(data_byte);
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    mode_next       = MODE_RUN;
                    run_value_next  = data_byte;
                    held_count_next = COUNT_W'(1);
                end
            end
        endcase

        if (is_last)
        begin
            mode_next       = MODE_IDLE;
            held_count_next = '0;
        end

        row_len = LEN_W'(row_total_reg + LEN_W'(a_valid ? pkt_a.len : '0)
                         + LEN_W'(b_valid ? pkt_b.len : '0));
    end

    // byte emission and word packing
    always_comb
    begin
        cur_pkt   = cmd.sel_b ? pkt_b_reg : pkt_a_reg;
        byte_last = (COUNT_W'(ptr_reg + COUNT_W'(1)) == cur_pkt.len);
        step_last = byte_last && (cmd.sel_b || !b_valid_reg);
        if (ptr_reg == '0)
        begin
            cur_byte = cur_pkt.header;
        end
        else if (!cur_pkt.is_lit)
        begin
            cur_byte = cur_pkt.value;
        end
        else if (ptr_reg == COUNT_W'(1))
        begin
            cur_byte = lead_byte_reg;
        end
        else
        begin
            cur_byte = mem_rdata_reg;
        end

        word_ins = word_reg;
        for (int i = 0; i < pbre_pkg::OUT_LANES; i++)
        begin
            if (fill_reg == LANE_W'(i))
            begin
                word_ins[i*BYTE_W +: BYTE_W] = cur_byte;
            end
        end
        fill_inc = LANE_W'(fill_reg + LANE_W'(1));
        flush    = cmd.emit && (byte_last || fill_inc == LANE_W'(pbre_pkg::OUT_LANES));
        out_free = !out_valid_reg || !out_stall;

        if (cmd.accept)
        begin
            ptr_next = '0;
        end
        else if (cmd.emit)
        begin
            ptr_next = byte_last ? '0 : COUNT_W'(ptr_reg + COUNT_W'(1));
        end
        else
        begin
            ptr_next = ptr_reg;
        end
        // read one ahead so the data lines up with the pointer after the edge
        mem_raddr = ADDR_W'(ptr_next - COUNT_W'(1));
    end

    always_comb
    begin
        status.new_has_a = a_valid;
        status.has_b     = b_valid_reg;
        status.byte_last = byte_last;
        status.out_free  = out_free;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we && cmd.accept)
        begin
            lit_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= lit_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg    <= COL_W'(1);
            rows_reg         <= ROW_W'(1);
            mode_reg         <= MODE_IDLE;
            run_value_reg    <= '0;
            held_count_reg   <= '0;
            pending_byte_reg <= '0;
            lead_byte_reg    <= '0;
            column_reg       <= '0;
            row_index_reg    <= '0;
            row_total_reg    <= '0;
            b_valid_reg      <= 1'b0;
            ptr_reg          <= '0;
            fill_reg         <= '0;
            word_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    pbre_pkg::REG_ROW_WIDTH:       row_width_reg <= cfg_data[COL_W-1:0];
                    pbre_pkg::REG_ROWS_IN_CHANNEL: rows_reg      <= cfg_data[ROW_W-1:0];
                    default:                       rows_reg      <= rows_reg;
                endcase
            end

            if (cmd.accept)
            begin
                mode_reg         <= mode_next;
                run_value_reg    <= run_value_next;
                held_count_reg   <= held_count_next;
                pending_byte_reg <= pending_byte_next;
                lead_byte_reg    <= lead_byte_next;
                b_valid_reg      <= b_valid;
                if (is_last)
                begin
                    column_reg    <= '0;
                    row_total_reg <= '0;
                    row_index_reg <= chan_done ? '0 : ROW_W'(row_index_reg + ROW_W'(1));
                end
                else
                begin
                    column_reg    <= COL_W'(column_reg + COL_W'(1));
                    row_total_reg <= row_len;
                end
            end

            ptr_reg <= ptr_next;

            if (cmd.emit)
            begin
                if (flush)
                begin
                    fill_reg <= '0;
                    word_reg <= '0;
                end
                else
                begin
                    fill_reg <= fill_inc;
                    word_reg <= word_ins;
                end
            end

            if (flush)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pkt_a_reg        <= pkt_a;
            pkt_b_reg        <= pkt_b;
            row_len_reg      <= row_len;
            row_end_flag_reg <= is_last;
            chan_flag_reg    <= chan_done;
        end
        if (flush)
        begin
            code_bytes      <= word_ins;
            byte_count      <= fill_inc;
            packet_end      <= byte_last;
            last            <= step_last;
            row_end         <= step_last && row_end_flag_reg;
            row_code_length <= (step_last && row_end_flag_reg) ? row_len_reg : '0;
            channel_end     <= step_last && row_end_flag_reg && chan_flag_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: sv/packbits_row_encoder_core.sv
// packbits row encoder: top level joining controller and datapath
// an input byte that closes no packet is taken without holding the input; one that
// closes packets then holds the input through in_stall while the byte-serial word packer
// emits the code bytes of its packets, and output stalls hold that emission
// throughput: one input byte per cycle inside runs and literals while in_stall is low
// reset clears control state and counters; the literal memory is not cleared
`timescale 1ns / 1ps

module packbits_row_encoder_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write_en,
    input  logic [pbre_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pbre_pkg::CFG_W-1:0]          cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [pbre_pkg::BYTE_W-1:0]         data_byte,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [pbre_pkg::CODE_W-1:0]         code_bytes,
    output logic [pbre_pkg::LANE_W-1:0]         byte_count,
    output logic                               packet_end,
    output logic                               row_end,
    output logic [pbre_pkg::LEN_W-1:0]          row_code_length,
    output logic                               channel_end,
    output logic                               last
);

    pbre_pkg::pbre_cmd_t    cmd;
    pbre_pkg::pbre_status_t status;

    pbre_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    pbre_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .data_byte       (data_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .code_bytes      (code_bytes),
        .byte_count      (byte_count),
        .packet_end      (packet_end),
        .row_end         (row_end),
        .row_code_length (row_code_length),
        .channel_end     (channel_end),
        .last            (last)
    );

`ifndef SYNTHESIS
    a_no_intake_while_emitting: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> !cmd.emit
    ) else $error("byte taken while packet emission in progress");

    a_row_end_closes_step: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && row_end) |-> (last && packet_end)
    ) else $error("row end word is not the closing word of a packet");

    a_channel_end_on_row_end: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && channel_end) |-> row_end
    ) else $error("channel end flagged without row end");

    a_byte_count_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (byte_count != '0 &&
                       byte_count <= pbre_pkg::LANE_W'(pbre_pkg::OUT_LANES))
    ) else $error("byte count out of range");
`endif

endmodule
